FILE: sv/frx_pkg.sv
// frx_pkg: shared types and codes for the sync/length/check frame receiver
// used by frx_core, the top level and the checker; no dependencies
`default_nettype none

package frx_pkg;

   localparam int KIND_W    = 2;
   localparam int DATA_W    = 8;
   localparam int TICK_W    = 16;
   localparam int EVENT_W   = 3;
   localparam int LEN_W     = 16;
   localparam int TOTAL_W   = 17;
   localparam int GAP_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 17;
   localparam int HDR_DEPTH = 5;
   localparam int HCNT_W    = 3;

   localparam logic [DATA_W-1:0]  SYNC_BYTE    = 8'h55;
   localparam logic [DATA_W-1:0]  MARKER_BYTE  = 8'h90;
   localparam logic [DATA_W-1:0]  CHECK_INVERT = 8'hFF;
   localparam logic [TOTAL_W-1:0] FRAME_EXTRA  = 17'd6;
   localparam logic [TOTAL_W-1:0] HEADER_LEN   = 17'd5;

   localparam logic [TOTAL_W-1:0] MAX_FRAME_RESET = 17'd2048;
   localparam logic [GAP_W-1:0]   GAP_LIMIT_RESET = 8'd3;

   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   localparam logic [EVENT_W-1:0] EV_HEADER   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_GOOD     = 3'd2;
   localparam logic [EVENT_W-1:0] EV_BAD      = 3'd3;
   localparam logic [EVENT_W-1:0] EV_TOO_LONG = 3'd4;
   localparam logic [EVENT_W-1:0] EV_GAP      = 3'd5;
   localparam logic [EVENT_W-1:0] EV_DEADLINE = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_FRAME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_LIMIT = 1'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] data;
      logic [TICK_W-1:0] wait_ticks;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic [EVENT_W-1:0] event_res;
      logic [DATA_W-1:0]  data_res;
      logic [LEN_W-1:0]   byte_index;
      logic [DATA_W-1:0]  status_byte;
      logic [LEN_W-1:0]   payload_length;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/sync_length_lrc_frame_receiver_unit.sv
// Frame receiver top level: request register, receive core, result register,
// control registers. Depends on frx_pkg and frx_core.
//
// Usage:
//   Requests (req_kind/req_data/req_wait_ticks) enter on req_valid while
//   req_stall is low: a start request arms an attempt with a tick deadline,
//   byte requests carry received link bytes, tick requests advance time.
//   Each request gives zero or one result on the rsp_ channel, taken on an
//   edge with rsp_valid high and rsp_stall low.
//   The accepted request waits in the request register; the result register
//   takes its result when the request advances, which rsp_stall can hold up.
//   Throughput: one request per cycle while the result register is free; the
//   single state update per request sits between the two registers.
//   When the receiver holds rsp_stall, the result register keeps its value
//   and the request register fills; req_stall then rises until the result
//   is taken.
//   Control registers are written through csr_valid/csr_index/csr_wdata,
//   always ready; write them only while no request is in flight.
//   Reset (synchronous) disarms the receiver, empties both registers and
//   restores max_frame_length 2048 and gap_limit 3.
`default_nettype none

module sync_length_lrc_frame_receiver_unit
   import frx_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [DATA_W-1:0]    req_data,
   input  wire logic [TICK_W-1:0]    req_wait_ticks,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [EVENT_W-1:0]        rsp_event_res,
   output logic [DATA_W-1:0]         rsp_data_res,
   output logic [LEN_W-1:0]          rsp_byte_index,
   output logic [DATA_W-1:0]         rsp_status_byte,
   output logic [LEN_W-1:0]          rsp_payload_length,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   logic               in_valid_ff;
   item_type           in_item_ff;
   result_type         out_ff;
   logic               out_valid_ff;
   logic [TOTAL_W-1:0] max_frame_ff;
   logic [GAP_W-1:0]   gap_limit_ff;
   logic               out_free;
   logic               advance;
   logic               req_take;
   result_type         core_res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   frx_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (in_item_ff),
      .max_frame (max_frame_ff),
      .gap_limit (gap_limit_ff),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_frame_ff <= MAX_FRAME_RESET;
         gap_limit_ff <= GAP_LIMIT_RESET;
      end else begin
         if (req_take || advance) begin
            in_valid_ff <= req_take;
         end
         if (out_free) begin
            out_valid_ff <= advance && core_res.valid;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MAX_FRAME: max_frame_ff <= csr_wdata;
               REG_GAP_LIMIT: gap_limit_ff <= csr_wdata[GAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind       <= req_kind;
         in_item_ff.data       <= req_data;
         in_item_ff.wait_ticks <= req_wait_ticks;
      end
      if (out_free) begin
         out_ff <= core_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_data_res       = out_ff.data_res;
   assign rsp_byte_index     = out_ff.byte_index;
   assign rsp_status_byte    = out_ff.status_byte;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_last           = out_ff.last;

endmodule

`default_nettype wire

FILE: sv/frx_core.sv
// frx_core: receive state and per-item update logic for the frame receiver
// depends on frx_pkg
`default_nettype none

module frx_core
   import frx_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire item_type           item,
   input  wire logic [TOTAL_W-1:0] max_frame,
   input  wire logic [GAP_W-1:0]   gap_limit,
   output result_type              result
);

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   logic                armed_ff, armed_in;
   phase_type           phase_ff, phase_in;
   logic [DATA_W-1:0]   hdr_ff [HDR_DEPTH];
   logic [DATA_W-1:0]   hdr_in [HDR_DEPTH];
   logic [HCNT_W-1:0]   hcount_ff, hcount_in;
   logic [TOTAL_W-1:0]  fcount_ff, fcount_in;
   logic [TOTAL_W-1:0]  ftotal_ff, ftotal_in;
   logic [DATA_W-1:0]   check_ff, check_in;
   logic [TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]   deadline_ff, deadline_in;
   logic [GAP_W-1:0]    silence_ff, silence_in;
   logic                seen_ff, seen_in;

   always_comb begin
      logic [DATA_W-1:0]  h [HDR_DEPTH];
      logic [HCNT_W-1:0]  cnt;
      logic [HCNT_W-1:0]  sh;
      logic [HCNT_W-1:0]  src;
      logic [LEN_W-1:0]   len;
      logic [TOTAL_W-1:0] total;
      logic [GAP_W-1:0]   sil;
      logic               clear;

      armed_in    = armed_ff;
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      hcount_in   = hcount_ff;
      fcount_in   = fcount_ff;
      ftotal_in   = ftotal_ff;
      check_in    = check_ff;
      elapsed_in  = elapsed_ff;
      deadline_in = deadline_ff;
      silence_in  = silence_ff;
      seen_in     = seen_ff;
      result      = '0;
      clear       = 1'b0;
      h           = hdr_ff;
      cnt         = hcount_ff;
      sh          = '0;
      src         = '0;
      len         = '0;
      total       = '0;
      sil         = silence_ff;

      if (item.kind == KIND_START) begin
         armed_in    = 1'b1;
         clear       = 1'b1;
         elapsed_in  = '0;
         deadline_in = item.wait_ticks;
         silence_in  = '0;
         seen_in     = 1'b0;
      end else if (armed_ff && item.kind == KIND_BYTE) begin
         seen_in    = 1'b1;
         silence_in = '0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (item.data == SYNC_BYTE) begin
                  hdr_in[0] = item.data;
                  hcount_in = HCNT_W'(1);
                  phase_in  = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if (hcount_ff > HCNT_W'(4)) begin
                  cnt = HCNT_W'(4);
               end
               h[cnt] = item.data;
               if (cnt != HCNT_W'(4)) begin
                  hdr_in    = h;
                  hcount_in = cnt + HCNT_W'(1);
               end else if (h[1] != MARKER_BYTE) begin
                  // rescan held bytes for a later sync byte
                  if (h[4] == SYNC_BYTE) sh = HCNT_W'(4);
                  if (h[3] == SYNC_BYTE) sh = HCNT_W'(3);
                  if (h[2] == SYNC_BYTE) sh = HCNT_W'(2);
                  if (h[1] == SYNC_BYTE) sh = HCNT_W'(1);
                  if (sh == '0) begin
                     clear = 1'b1;
                  end else begin
                     hdr_in = h;
                     for (int j = 0; j < HDR_DEPTH - 1; j++) begin
                        src = HCNT_W'(j) + sh;
                        if (src < HCNT_W'(HDR_DEPTH)) begin
                           hdr_in[j] = h[src];
                        end
                     end
                     hcount_in = HCNT_W'(HDR_DEPTH) - sh;
                  end
               end else begin
                  hdr_in = h;
                  len    = {h[3], h[4]};
                  total  = FRAME_EXTRA + TOTAL_W'(len);
                  result.payload_length = len;
                  result.valid          = 1'b1;
                  if (total > max_frame) begin
                     clear            = 1'b1;
                     result.event_res = EV_TOO_LONG;
                  end else begin
                     ftotal_in          = total;
                     fcount_in          = HEADER_LEN;
                     check_in           = h[1] ^ h[2] ^ h[3] ^ h[4];
                     phase_in           = PH_BODY;
                     result.event_res   = EV_HEADER;
                     result.status_byte = h[2];
                  end
               end
            end
            default: begin
               result.valid    = 1'b1;
               result.data_res = item.data;
               if ({1'b0, fcount_ff} + 18'd1 < {1'b0, ftotal_ff}) begin
                  check_in          = check_ff ^ item.data;
                  fcount_in         = fcount_ff + TOTAL_W'(1);
                  result.event_res  = EV_PAYLOAD;
                  result.byte_index = LEN_W'(fcount_ff - HEADER_LEN);
               end else if ((check_ff ^ CHECK_INVERT) == item.data) begin
                  clear            = 1'b1;
                  armed_in         = 1'b0;
                  result.event_res = EV_GOOD;
                  result.last      = 1'b1;
               end else begin
                  clear            = 1'b1;
                  result.event_res = EV_BAD;
               end
            end
         endcase
      end else if (armed_ff && item.kind == KIND_TICK) begin
         if (elapsed_ff >= deadline_ff) begin
            armed_in         = 1'b0;
            clear            = 1'b1;
            result.valid     = 1'b1;
            result.event_res = EV_DEADLINE;
            result.last      = 1'b1;
         end else begin
            elapsed_in = elapsed_ff + TICK_W'(1);
            if (seen_ff) begin
               if (silence_ff != '1) begin
                  sil = silence_ff + GAP_W'(1);
               end
               silence_in = sil;
               if (sil >= gap_limit) begin
                  armed_in         = 1'b0;
                  clear            = 1'b1;
                  result.valid     = 1'b1;
                  result.event_res = EV_GAP;
                  result.last      = 1'b1;
               end
            end
         end
      end

      if (clear) begin
         phase_in  = PH_HUNT;
         hcount_in = '0;
         fcount_in = '0;
         ftotal_in = '0;
         check_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         phase_ff    <= PH_HUNT;
         hcount_ff   <= '0;
         fcount_ff   <= '0;
         ftotal_ff   <= '0;
         check_ff    <= '0;
         elapsed_ff  <= '0;
         deadline_ff <= '0;
         silence_ff  <= '0;
         seen_ff     <= 1'b0;
      end else if (fire) begin
         armed_ff    <= armed_in;
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         fcount_ff   <= fcount_in;
         ftotal_ff   <= ftotal_in;
         check_ff    <= check_in;
         elapsed_ff  <= elapsed_in;
         deadline_ff <= deadline_in;
         silence_ff  <= silence_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hdr_ff <= hdr_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/frx_checker.sv
// frx_checker: port-level assertions for the frame receiver, bound to the top
// depends on frx_pkg and sync_length_lrc_frame_receiver_unit
`default_nettype none

module frx_checker
   import frx_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [EVENT_W-1:0] rsp_event_res,
   input wire logic [DATA_W-1:0]  rsp_data_res,
   input wire logic [LEN_W-1:0]   rsp_byte_index,
   input wire logic [DATA_W-1:0]  rsp_status_byte,
   input wire logic [LEN_W-1:0]   rsp_payload_length,
   input wire logic               rsp_last
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_data_res) && $stable(rsp_byte_index) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_last_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_event_res == EV_GOOD
         || rsp_event_res == EV_GAP || rsp_event_res == EV_DEADLINE))
      else $error("last flag disagrees with event");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_HEADER |->
         rsp_data_res == '0 && rsp_byte_index == '0)
      else $error("header event carries payload fields");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_PAYLOAD |->
         rsp_status_byte == '0 && rsp_payload_length == '0)
      else $error("payload event carries header fields");

endmodule

bind sync_length_lrc_frame_receiver_unit frx_checker u_frx_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_event_res      (rsp_event_res),
   .rsp_data_res       (rsp_data_res),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_status_byte    (rsp_status_byte),
   .rsp_payload_length (rsp_payload_length),
   .rsp_last           (rsp_last)
);

`default_nettype wire

FILE: tb/frx_frame_checker.sv
// frx_frame_checker: watches the request, result and register channels of the
// frame receiver, predicts each result and compares it field by field.
// Depends on frx_pkg; instantiated beside the block by the testbench top.
`default_nettype none

module frx_frame_checker
   import frx_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [DATA_W-1:0]    req_data,
   input  wire logic [TICK_W-1:0]    req_wait_ticks,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [EVENT_W-1:0]   rsp_event_res,
   input  wire logic [DATA_W-1:0]    rsp_data_res,
   input  wire logic [LEN_W-1:0]     rsp_byte_index,
   input  wire logic [DATA_W-1:0]    rsp_status_byte,
   input  wire logic [LEN_W-1:0]     rsp_payload_length,
   input  wire logic                 rsp_last,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,
   output int                        errors,
   output int                        pending,
   output int                        results_checked,
   output int                        good_frames,
   output logic [EV_DEADLINE:0]      events_seen
);

   localparam logic [1:0] RX_HUNT   = 2'd0;
   localparam logic [1:0] RX_HEADER = 2'd1;
   localparam logic [1:0] RX_BODY   = 2'd2;
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [EVENT_W-1:0] code;
      logic [DATA_W-1:0]  data;
      logic [LEN_W-1:0]   index;
      logic [DATA_W-1:0]  status;
      logic [LEN_W-1:0]   length;
      logic               last;
   } frame_event_type;

   frame_event_type expected_events[$];

   bit                armed;
   logic [1:0]        rx_phase;
   logic [DATA_W-1:0] hdr [HDR_DEPTH];
   int                hdr_count;
   int                frame_count;
   int                frame_total;
   logic [DATA_W-1:0] lrc;
   int                elapsed;
   int                deadline;
   int                silence;
   bit                byte_seen;
   int                max_frame;
   int                gap_limit;

   initial begin
      errors = 0;
      pending = 0;
      results_checked = 0;
      good_frames = 0;
      events_seen = '0;
   end

   task automatic report_mismatch(input string msg);
      if (errors < MAX_REPORTS)
         $display("%0t: mismatch: %s", $time, msg);
      errors++;
   endtask

   function automatic void restart_hunt();
      rx_phase = RX_HUNT;
      hdr_count = 0;
      frame_count = 0;
      frame_total = 0;
      lrc = '0;
   endfunction

   function automatic void reset_receiver();
      max_frame = MAX_FRAME_RESET;
      gap_limit = GAP_LIMIT_RESET;
      armed = 0;
      restart_hunt();
      elapsed = 0;
      deadline = 0;
      silence = 0;
      byte_seen = 0;
   endfunction

   // returns 1 when the request yields a result
   function automatic bit take_request(input logic [KIND_W-1:0] kind,
                                       input logic [DATA_W-1:0] d,
                                       input logic [TICK_W-1:0] w,
                                       output frame_event_type ev);
      int at;
      int len;
      ev = '0;
      if (kind == KIND_START) begin
         armed = 1;
         restart_hunt();
         elapsed = 0;
         deadline = w;
         silence = 0;
         byte_seen = 0;
         return 0;
      end
      if (!armed || (kind != KIND_BYTE && kind != KIND_TICK))
         return 0;
      if (kind == KIND_TICK) begin
         if (elapsed >= deadline) begin
            armed = 0;
            restart_hunt();
            ev.code = EV_DEADLINE;
            ev.last = 1'b1;
            return 1;
         end
         elapsed++;
         if (byte_seen) begin
            if (silence < 255)
               silence++;
            if (silence >= gap_limit) begin
               armed = 0;
               restart_hunt();
               ev.code = EV_GAP;
               ev.last = 1'b1;
               return 1;
            end
         end
         return 0;
      end
      byte_seen = 1;
      silence = 0;
      if (rx_phase == RX_HUNT) begin
         if (d == SYNC_BYTE) begin
            hdr[0] = d;
            hdr_count = 1;
            rx_phase = RX_HEADER;
         end
         return 0;
      end
      if (rx_phase == RX_HEADER) begin
         hdr[hdr_count] = d;
         hdr_count++;
         if (hdr_count < HDR_DEPTH)
            return 0;
         if (hdr[1] != MARKER_BYTE) begin
            // look for a later sync inside the held header
            at = 1;
            while (at < HDR_DEPTH && hdr[at] != SYNC_BYTE)
               at++;
            if (at == HDR_DEPTH)
               restart_hunt();
            else begin
               for (int j = at; j < HDR_DEPTH; j++)
                  hdr[j - at] = hdr[j];
               hdr_count = HDR_DEPTH - at;
            end
            return 0;
         end
         len = {hdr[3], hdr[4]};
         ev.length = LEN_W'(len);
         if (len + int'(FRAME_EXTRA) > max_frame) begin
            restart_hunt();
            ev.code = EV_TOO_LONG;
            return 1;
         end
         frame_total = len + int'(FRAME_EXTRA);
         frame_count = HEADER_LEN;
         lrc = hdr[1] ^ hdr[2] ^ hdr[3] ^ hdr[4];
         rx_phase = RX_BODY;
         ev.code = EV_HEADER;
         ev.status = hdr[2];
         return 1;
      end
      ev.data = d;
      if (frame_count + 1 < frame_total) begin
         ev.code = EV_PAYLOAD;
         ev.index = LEN_W'(frame_count - int'(HEADER_LEN));
         lrc ^= d;
         frame_count++;
         return 1;
      end
      if ((lrc ^ CHECK_INVERT) == d) begin
         ev.code = EV_GOOD;
         ev.last = 1'b1;
         armed = 0;
      end else
         ev.code = EV_BAD;
      restart_hunt();
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      frame_event_type want;
      frame_event_type got;
      if (reset) begin
         reset_receiver();
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_MAX_FRAME)
               max_frame = csr_wdata[TOTAL_W-1:0];
            else if (csr_index == REG_GAP_LIMIT)
               gap_limit = csr_wdata[GAP_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_event_res, rsp_data_res, rsp_byte_index, rsp_status_byte,
                    rsp_payload_length, rsp_last};
            results_checked++;
            if (got.code <= EV_DEADLINE)
               events_seen[got.code] = 1'b1;
            if (expected_events.size() == 0)
               report_mismatch($sformatf("result event_res %0d with none expected",
                                         got.code));
            else begin
               want = expected_events.pop_front();
               if (got.code != want.code)
                  report_mismatch($sformatf("event_res got %0d expected %0d",
                                            got.code, want.code));
               if (got.data != want.data)
                  report_mismatch($sformatf("data_res got %0d expected %0d (event %0d)",
                                            got.data, want.data, want.code));
               if (got.index != want.index)
                  report_mismatch($sformatf("byte_index got %0d expected %0d",
                                            got.index, want.index));
               if (got.status != want.status)
                  report_mismatch($sformatf("status_byte got %0d expected %0d",
                                            got.status, want.status));
               if (got.length != want.length)
                  report_mismatch($sformatf("payload_length got %0d expected %0d",
                                            got.length, want.length));
               if (got.last != want.last)
                  report_mismatch($sformatf("last got %0d expected %0d (event %0d)",
                                            got.last, want.last, want.code));
               if (want.code == EV_GOOD)
                  good_frames++;
            end
         end
         if (req_valid && !req_stall) begin
            if (take_request(req_kind, req_data, req_wait_ticks, want))
               expected_events.push_back(want);
         end
      end
      pending = expected_events.size();
   end

endmodule

`default_nettype wire

FILE: tb/sync_length_lrc_frame_receiver_unit_tb.sv
// Testbench top for the frame receiver: clock, reset, request and register
// stimulus, receiver stalls, watchdog and verdict.
// Depends on frx_pkg, sync_length_lrc_frame_receiver_unit and frx_frame_checker.
`default_nettype none

module sync_length_lrc_frame_receiver_unit_tb;
   import frx_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 250;
   localparam int NUM_PHASES  = 6;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind = KIND_BYTE;
   logic [DATA_W-1:0]    req_data = '0;
   logic [TICK_W-1:0]    req_wait_ticks = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [EVENT_W-1:0]   rsp_event_res;
   logic [DATA_W-1:0]    rsp_data_res;
   logic [LEN_W-1:0]     rsp_byte_index;
   logic [DATA_W-1:0]    rsp_status_byte;
   logic [LEN_W-1:0]     rsp_payload_length;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_MAX_FRAME;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   int                   errors;
   int                   pending;
   int                   results_checked;
   int                   good_frames;
   logic [EV_DEADLINE:0] events_seen;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holds_wanted = 0;
   int holds_done = 0;
   int hold_left = 0;
   int requests_sent = 0;
   int cur_max_frame = MAX_FRAME_RESET;
   int idle_cycles = 0;

   sync_length_lrc_frame_receiver_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_data(req_data), .req_wait_ticks(req_wait_ticks),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
      .rsp_data_res(rsp_data_res), .rsp_byte_index(rsp_byte_index),
      .rsp_status_byte(rsp_status_byte), .rsp_payload_length(rsp_payload_length),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   frx_frame_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_data(req_data), .req_wait_ticks(req_wait_ticks),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
      .rsp_data_res(rsp_data_res), .rsp_byte_index(rsp_byte_index),
      .rsp_status_byte(rsp_status_byte), .rsp_payload_length(rsp_payload_length),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .results_checked(results_checked),
      .good_frames(good_frames), .events_seen(events_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin : rsp_side
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done < holds_wanted) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic push_request(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] d,
                               input logic [TICK_W-1:0] w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_data <= d;
      req_wait_ticks <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_byte(input logic [DATA_W-1:0] d);
      push_request(KIND_BYTE, d, TICK_W'($urandom));
   endtask

   task automatic send_tick();
      push_request(KIND_TICK, DATA_W'($urandom), TICK_W'($urandom));
   endtask

   task automatic send_start(input logic [TICK_W-1:0] w);
      push_request(KIND_START, DATA_W'($urandom), w);
   endtask

   // sender pause until every expected result is in, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(input int max_len, input int gap);
      csr_valid <= 1'b1;
      csr_index <= REG_MAX_FRAME;
      csr_wdata <= CSR_DAT_W'(max_len);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_index <= REG_GAP_LIMIT;
      csr_wdata <= CSR_DAT_W'(gap);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      cur_max_frame = max_len;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      int near;
      r = $urandom_range(0, 99);
      if (r < 65)
         return LEN_W'($urandom_range(0, 12));
      if (r < 85 && cur_max_frame <= 400) begin
         near = cur_max_frame - 7 + $urandom_range(0, 2);
         return (near < 0) ? '0 : LEN_W'(near);
      end
      return LEN_W'($urandom);
   endfunction

   // sync, marker, status, length, then sent_len body bytes and the check byte
   // when the body is complete
   task automatic send_frame(input logic [LEN_W-1:0] len, input int sent_len,
                             input bit corrupt);
      logic [DATA_W-1:0] status;
      logic [DATA_W-1:0] check;
      logic [DATA_W-1:0] b;
      status = DATA_W'($urandom);
      check = MARKER_BYTE ^ status ^ len[15:8] ^ len[7:0];
      send_byte(SYNC_BYTE);
      send_byte(MARKER_BYTE);
      send_byte(status);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      for (int i = 0; i < sent_len; i++) begin
         if ($urandom_range(0, 99) < 6)
            send_tick();
         b = DATA_W'($urandom);
         check ^= b;
         send_byte(b);
      end
      if (sent_len == len) begin
         if (corrupt)
            send_byte(check ^ CHECK_INVERT ^ DATA_W'($urandom_range(1, 255)));
         else
            send_byte(check ^ CHECK_INVERT);
      end
   endtask

   task automatic run_attempt();
      int r;
      int frames;
      int style;
      int sent;
      logic [LEN_W-1:0] len;
      logic [DATA_W-1:0] junk;
      if ($urandom_range(0, 19) == 0)
         push_request(KIND_SPARE, DATA_W'($urandom), TICK_W'($urandom));
      r = $urandom_range(0, 99);
      if (r < 10)
         send_start(TICK_W'($urandom_range(0, 4)));
      else if (r < 15)
         send_start(16'hFFFF);
      else
         send_start(TICK_W'($urandom_range(16, 600)));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
         style = $urandom_range(0, 99);
         len = pick_length();
         sent = (len > 48) ? int'($urandom_range(0, 48)) : int'(len);
         if (style < 12)
            repeat ($urandom_range(1, 4)) send_byte(DATA_W'($urandom));
         else if (style < 20) begin
            // false sync ahead of the real header
            junk = DATA_W'($urandom);
            if (junk == MARKER_BYTE)
               junk = SYNC_BYTE;
            send_byte(SYNC_BYTE);
            send_byte(junk);
         end else if (style < 25)
            sent = int'($urandom_range(0, sent));
         send_frame(len, sent, style >= 25 && style < 35);
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) send_tick();
   endtask

   initial begin : stimulus
      int phase_goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 46;

      // ignored while disarmed, spare kind, immediate deadline, restart
      send_byte(SYNC_BYTE);
      send_tick();
      push_request(KIND_SPARE, 8'hFF, 16'hFFFF);
      send_start(16'h0000);
      send_tick();
      send_start(16'hFFFF);
      send_start(16'hFFFF);
      // bad marker, header recovered by rescan, one payload byte, bad check
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
      send_byte(MARKER_BYTE);
      send_byte(8'hA5);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h00);
      // longest length, dropped as too long
      send_byte(SYNC_BYTE);
      send_byte(MARKER_BYTE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      // silence after bytes breaks the attempt
      repeat (3) send_tick();

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: program_regs(6, 1);
            1: program_regs(65541, 255);
            2: program_regs(5, 0);
            3: program_regs(40, 4);
            4: program_regs(300, 8);
            default: program_regs(131071, 2);
         endcase
         if (p == 2) begin
            send_idle_pct = 46;
            recv_idle_pct = 14;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            holds_wanted++;
         end
         phase_goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_goal)
            run_attempt();
      end
      drain();

      $display("%0d requests over %0d register settings, %0d results checked",
               requests_sent, NUM_PHASES + 1, results_checked);
      $display("%0d good frames; result kinds seen (deadline down to header): %b",
               good_frames, events_seen);
      if (errors == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
sv/frx_pkg.sv
sv/frx_core.sv
sv/sync_length_lrc_frame_receiver_unit.sv
sv/frx_checker.sv
tb/frx_frame_checker.sv
tb/sync_length_lrc_frame_receiver_unit_tb.sv
